FILE: hdl/vv2d_pkg.sv
// Shared types and constants for the 2D velocity Verlet step block.
// Used by vv2d_div, vv2d_lane and velocity_verlet_2d_step; no dependencies.
package vv2d_pkg;

  // Time step 0.001 in Q0.24 and its square in Q0.48
  localparam int DT_INT = 16777;
  localparam logic signed [15:0] DT_Q24  = 16'(DT_INT);
  localparam logic signed [29:0] DT2_Q48 = 30'(DT_INT * DT_INT);

  // Numerator |F| * 4096 needs 24 + 12 bits
  localparam int DIV_W     = 36;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [15:0] MASS_RESET = 16'd256;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_MASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd2;

  typedef struct packed {
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_acc_x;
    logic signed [31:0] new_acc_y;
  } out_item_t;

  // Request from the top level to one axis lane
  typedef struct packed {
    logic               start;
    logic               restart;
    logic signed [23:0] frc;
    logic signed [31:0] start_pos;
    logic        [15:0] mass;
  } lane_req_t;

  // Status and results of one axis lane
  typedef struct packed {
    logic               done;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } lane_res_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_MUL,
    L_DISP,
    L_POS,
    L_DIV,
    L_ACC,
    L_VMUL,
    L_VEL,
    L_DONE
  } lane_state_e;

  typedef enum logic {
    T_IDLE,
    T_BUSY
  } top_state_e;

endpackage

FILE: hdl/vv2d_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on vv2d_pkg for the operand widths.
module vv2d_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vv2d_pkg::DIV_W-1:0]  numer_i,
  input  logic [15:0]                 denom_i,
  output logic                        done_o,
  output logic [vv2d_pkg::DIV_W-1:0]  quot_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [vv2d_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [vv2d_pkg::DIV_W-1:0]     num_q, num_d;
  logic [15:0]                    rem_q, rem_d;
  logic [15:0]                    den_q, den_d;

  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;

  assign shifted = {rem_q, num_q[vv2d_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = vv2d_pkg::DIV_CNT_W'(vv2d_pkg::DIV_W);
      num_d  = numer_i;
      rem_d  = '0;
      den_d  = denom_i;
    end else if (busy_q) begin
      // remainder stays below a nonzero divisor, so 16 bits hold it either way
      rem_d = ge ? diff[15:0] : shifted[15:0];
      num_d = {num_q[vv2d_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == vv2d_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: hdl/vv2d_lane.sv
// One axis of the Verlet step: position, velocity and acceleration state,
// sequencer, multiplies and saturation. Depends on vv2d_pkg and vv2d_div.
module vv2d_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vv2d_pkg::lane_req_t req_i,
  input  logic                ack_i,
  output vv2d_pkg::lane_res_t res_o
);

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  vv2d_pkg::lane_state_e state_q, state_d;

  logic signed [31:0] pos_q, vel_q, acc_q;
  logic signed [23:0] frc_q;
  logic signed [47:0] prod_v_q;
  logic signed [61:0] prod_a_q;
  logic signed [48:0] disp_q;
  logic signed [32:0] sum_q;
  logic signed [48:0] vprod_q;

  logic                       div_start;
  logic                       div_done;
  logic [vv2d_pkg::DIV_W-1:0] quot;
  logic [23:0]                frc_mag;

  logic signed [36:0] rnd_a;
  logic signed [48:0] disp_d;
  logic signed [25:0] pos_inc;
  logic signed [33:0] pos_sum;
  logic signed [31:0] acc_new;
  logic signed [24:0] vel_inc;
  logic signed [33:0] vel_sum;

  // magnitude as unsigned, so the most negative force maps to 2^23
  assign frc_mag = frc_q[23] ? 24'(-frc_q) : 24'(frc_q);

  vv2d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i ({frc_mag, 12'b0}),
    .denom_i (req_i.mass),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // position update: v*dt + rnd(a*dt^2, 25), then to Q16.16
  assign rnd_a   = 37'((prod_a_q + 62'sd16777216) >>> 25);
  assign disp_d  = 49'(prod_v_q) + 49'(rnd_a);
  assign pos_inc = 26'((50'(disp_q) + 50'sd8388608) >>> 24);
  assign pos_sum = 34'(pos_q) + 34'(pos_inc);

  // truncating division on magnitudes; zero force gives zero even for zero mass
  always_comb begin
    if (frc_q == 24'sd0) begin
      acc_new = 32'sd0;
    end else if (frc_q[23]) begin
      if (quot > 36'h080000000) begin
        acc_new = 32'sh80000000;
      end else begin
        acc_new = -$signed(quot[31:0]);
      end
    end else begin
      if (quot > 36'h07FFFFFFF) begin
        acc_new = 32'sh7FFFFFFF;
      end else begin
        acc_new = $signed(quot[31:0]);
      end
    end
  end

  assign vel_inc = 25'((vprod_q + 49'sd16777216) >>> 25);
  assign vel_sum = 34'(vel_q) + 34'(vel_inc);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vv2d_pkg::L_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.restart ? vv2d_pkg::L_DONE : vv2d_pkg::L_MUL;
        end
      end
      vv2d_pkg::L_MUL:  state_d = vv2d_pkg::L_DISP;
      vv2d_pkg::L_DISP: state_d = vv2d_pkg::L_POS;
      vv2d_pkg::L_POS:  state_d = vv2d_pkg::L_DIV;
      vv2d_pkg::L_DIV: begin
        if (div_done) begin
          state_d = vv2d_pkg::L_ACC;
        end
      end
      vv2d_pkg::L_ACC:  state_d = vv2d_pkg::L_VMUL;
      vv2d_pkg::L_VMUL: state_d = vv2d_pkg::L_VEL;
      vv2d_pkg::L_VEL:  state_d = vv2d_pkg::L_DONE;
      vv2d_pkg::L_DONE: begin
        if (ack_i) begin
          state_d = vv2d_pkg::L_IDLE;
        end
      end
      default: state_d = vv2d_pkg::L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_start  = (state_q == vv2d_pkg::L_POS);
    res_o.done = (state_q == vv2d_pkg::L_DONE);
    res_o.pos  = pos_q;
    res_o.vel  = vel_q;
    res_o.acc  = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vv2d_pkg::L_IDLE;
      pos_q   <= '0;
      vel_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        vv2d_pkg::L_IDLE: begin
          if (req_i.start && req_i.restart) begin
            pos_q <= req_i.start_pos;
            vel_q <= '0;
            acc_q <= '0;
          end
        end
        vv2d_pkg::L_POS: pos_q <= sat32(pos_sum);
        vv2d_pkg::L_ACC: acc_q <= acc_new;
        vv2d_pkg::L_VEL: vel_q <= sat32(vel_sum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == vv2d_pkg::L_IDLE && req_i.start) begin
      frc_q <= req_i.frc;
    end
    if (state_q == vv2d_pkg::L_MUL) begin
      prod_v_q <= 48'(vel_q) * 48'(vv2d_pkg::DT_Q24);
      prod_a_q <= 62'(acc_q) * 62'(vv2d_pkg::DT2_Q48);
    end
    if (state_q == vv2d_pkg::L_DISP) begin
      disp_q <= disp_d;
    end
    if (state_q == vv2d_pkg::L_ACC) begin
      sum_q <= 33'(acc_q) + 33'(acc_new);
    end
    if (state_q == vv2d_pkg::L_VMUL) begin
      vprod_q <= 49'(sum_q) * 49'(vv2d_pkg::DT_Q24);
    end
  end

endmodule

FILE: hdl/velocity_verlet_2d_step.sv
// An input beat for an integration step reaches out_valid_o after each axis lane's sequence,
// which waits on its radix-2 divider; a restart beat skips the sequence and the divider.
// One item in flight; the output register frees the lanes so the next input beat is
// taken while a result waits.
// Reset (rst_ni low, async): position, velocity, acceleration and start registers zero,
// body_mass 1.0, no result pending.
module velocity_verlet_2d_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  vv2d_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vv2d_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vv2d_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  vv2d_pkg::top_state_e state_q, state_d;

  logic [15:0]        mass_q;
  logic signed [31:0] start_x_q, start_y_q;

  logic                out_valid_q;
  vv2d_pkg::out_item_t out_data_q;

  logic                in_fire;
  logic                out_load;
  logic                lane_ack;
  logic                slot_free;
  vv2d_pkg::lane_req_t req_x, req_y;
  vv2d_pkg::lane_res_t res_x, res_y;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    req_x.start     = in_fire;
    req_x.restart   = in_data_i.restart;
    req_x.frc       = in_data_i.force_x;
    req_x.start_pos = start_x_q;
    req_x.mass      = mass_q;
    req_y.start     = in_fire;
    req_y.restart   = in_data_i.restart;
    req_y.frc       = in_data_i.force_y;
    req_y.start_pos = start_y_q;
    req_y.mass      = mass_q;
  end

  vv2d_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_x),
    .ack_i  (lane_ack),
    .res_o  (res_x)
  );

  vv2d_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_y),
    .ack_i  (lane_ack),
    .res_o  (res_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vv2d_pkg::T_IDLE: begin
        if (in_valid_i) begin
          state_d = vv2d_pkg::T_BUSY;
        end
      end
      vv2d_pkg::T_BUSY: begin
        if (res_x.done && res_y.done && slot_free) begin
          state_d = vv2d_pkg::T_IDLE;
        end
      end
      default: state_d = vv2d_pkg::T_IDLE;
    endcase
  end

  // outputs: input ready, and when to load both lanes into the result beat
  always_comb begin
    in_ready_o = (state_q == vv2d_pkg::T_IDLE);
    out_load   = (state_q == vv2d_pkg::T_BUSY) && res_x.done && res_y.done && slot_free;
    lane_ack   = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vv2d_pkg::T_IDLE;
      out_valid_q <= 1'b0;
      mass_q      <= vv2d_pkg::MASS_RESET;
      start_x_q   <= '0;
      start_y_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vv2d_pkg::CFG_BODY_MASS: mass_q    <= cfg_data_i[15:0];
          vv2d_pkg::CFG_START_X:   start_x_q <= cfg_data_i;
          vv2d_pkg::CFG_START_Y:   start_y_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.new_pos_x <= res_x.pos;
      out_data_q.new_pos_y <= res_y.pos;
      out_data_q.new_vel_x <= res_x.vel;
      out_data_q.new_vel_y <= res_y.vel;
      out_data_q.new_acc_x <= res_x.acc;
      out_data_q.new_acc_y <= res_y.acc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // both lanes run the same sequence and must finish together
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_x.done == res_y.done)
    else $error("axis lanes out of step");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while item in flight");

  a_idle_lanes_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_x.done)
    else $error("lane result left behind while idle");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");
`endif

endmodule
